[rtl/kbsh_pkg.sv]
// Shared types, constants and lane functions for the keyed byte stream hash.
package kbsh_pkg;

    // Lane set carried through the update and finalize stages
    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } lanes_t;

    // Input word kinds (tuser)
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_BYTE  = 1'b1;

    // Key path modes
    localparam logic [1:0] MODE_SHORT = 2'd0;
    localparam logic [1:0] MODE_BLOCK = 2'd1;
    localparam logic [1:0] MODE_TAIL  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_SEED0 = 2'd0;
    localparam logic [1:0] REG_SEED1 = 2'd1;
    localparam logic [1:0] REG_SEED2 = 2'd2;

    // Lane init multipliers
    localparam logic [31:0] INIT_MUL_A = 32'h940C_F22F;
    localparam logic [31:0] INIT_MUL_B = 32'h82AD_1DB1;
    localparam logic [31:0] INIT_MUL_C = 32'hA250_D491;
    localparam logic [31:0] INIT_MUL_D = 32'hBAC9_A9D9;

    // Long-key end marker XORed into lane d
    localparam logic [31:0] END_MARK = 32'h0000_00FF;

    // Longest short key in bytes; longer keys use words
    localparam logic [31:0] SHORT_MAX = 32'd12;
    localparam logic [31:0] BLOCK_BYTES = 32'd16;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    // Block mixer
    function automatic lanes_t mix6(input lanes_t l);
        lanes_t m;
        m = l;
        m.a = rotl(m.a, 23) ^ m.d;
        m.b = rotl(m.b, 5) + m.c;
        m.d = m.d + m.b;
        m.c = rotl(m.c, 3) + m.a;
        m.a = rotl(m.a, 12) + m.d;
        m.b = m.b ^ m.c;
        m.d = rotl(m.d, 19) - m.b;
        m.c = rotl(m.c, 22) ^ m.a;
        return m;
    endfunction

    // Finalizer, first half
    function automatic lanes_t fin_lo(input lanes_t l);
        lanes_t m;
        m = l;
        m.b = m.b + m.d;
        m.a = m.a ^ m.c;
        m.b = rotl(m.b, 6) - m.a;
        m.d = m.d - m.b;
        m.b = rotl(m.b, 10) ^ m.d;
        m.d = rotl(m.d, 5) + m.b;
        m.c = rotl(m.c, 13) ^ m.d;
        m.d = rotl(m.d, 17) + m.c;
        return m;
    endfunction

    // Finalizer, second half
    function automatic lanes_t fin_hi(input lanes_t l);
        lanes_t m;
        m = l;
        m.c = rotl(m.c, 15) ^ m.d;
        m.a = m.a + m.c;
        m.b = m.b ^ m.a;
        m.c = rotl(m.c, 9) - m.b;
        m.a = rotl(m.a, 22) + m.c;
        m.b = rotl(m.b, 18) - m.a;
        m.d = rotl(m.d, 22) + m.b;
        m.a = rotl(m.a, 4);
        m.b = rotl(m.b, 11) - m.a;
        return m;
    endfunction

endpackage

[rtl/keyed_byte_stream_hash32.sv]
// Keyed byte stream hash: input register, lane update, four finalize stages, output register.
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_tvalid/s_tready  tdata: key_length, key_byte; tuser: command
//  m_       out        m_tvalid/m_tready  tdata: hash_value
//  cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data (seed words)
//
// One input word per cycle while the output is not stalled. After the word that ends the
// key, a hash is registered through lane update, long-key mix, two finalizer halves and
// lane fold. The lane update with its one block mix is the loop that sets the cycle time.
// aresetn is synchronous; it clears lanes, counters and all valid bits.
// A stalled output freezes the whole pipe; s_tready follows m_tready then.
module keyed_byte_stream_hash32 (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] key_length, [39:32] key_byte
    input  logic        s_tuser,   // [0] command
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] hash_value
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    // Seed registers
    logic [31:0] seed0_reg, seed1_reg, seed2_reg;

    // Input register
    logic        in_valid_reg;
    logic        in_cmd_reg;
    logic [31:0] in_len_reg;
    logic [7:0]  in_byte_reg;
    logic [31:0] in_pa_reg, in_pb_reg, in_pc_reg, in_pd_reg;

    // Key state
    kbsh_pkg::lanes_t lanes_reg, lanes_next;
    logic [31:0] rem_reg, rem_next;
    logic [23:0] wasm_reg, wasm_next;
    logic [3:0]  pos_reg, pos_next;
    logic [1:0]  mode_reg, mode_next;
    logic        active_reg, active_next;

    // Finalize pipe
    logic             emit;
    logic             emit_long;
    logic [4:0]       emit_tag;
    logic             f1_valid_reg, fm_valid_reg, f2_valid_reg, f3_valid_reg;
    logic             f1_long_reg;
    logic [4:0]       f1_tag_reg;
    kbsh_pkg::lanes_t f1_lanes_reg, fm_lanes_reg, f2_lanes_reg, f3_lanes_reg;
    kbsh_pkg::lanes_t f1_work;

    // Output register
    logic        m_valid_reg;
    logic [31:0] m_data_reg;

    logic        adv;
    logic [31:0] s_len;

    assign adv       = !m_valid_reg || m_tready;
    assign s_tready  = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign s_len     = s_tdata[31:0];

    // Seed writes; indexes past the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed0_reg <= '0;
            seed1_reg <= '0;
            seed2_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                kbsh_pkg::REG_SEED0: seed0_reg <= cfg_data;
                kbsh_pkg::REG_SEED1: seed1_reg <= cfg_data;
                kbsh_pkg::REG_SEED2: seed2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register; init products are formed on the way in
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (adv) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_tvalid) begin
            in_cmd_reg  <= s_tuser;
            in_len_reg  <= s_len;
            in_byte_reg <= s_tdata[39:32];
            in_pa_reg   <= 32'(kbsh_pkg::INIT_MUL_A * (s_len + 32'd1));
            in_pb_reg   <= 32'(kbsh_pkg::INIT_MUL_B * (s_len + 32'd2));
            in_pc_reg   <= 32'(kbsh_pkg::INIT_MUL_C * (s_len + 32'd3));
            in_pd_reg   <= 32'(kbsh_pkg::INIT_MUL_D * (s_len + 32'd4));
        end
    end

    // Lane update for one word
    always_comb begin
        logic [4:0]  sh;
        logic [31:0] bext;
        logic [31:0] word;
        logic [7:0]  r;
        logic [1:0]  t;
        logic [1:0]  w;
        logic [1:0]  s;

        lanes_next  = lanes_reg;
        rem_next    = rem_reg;
        wasm_next   = wasm_reg;
        pos_next    = pos_reg;
        mode_next   = mode_reg;
        active_next = active_reg;
        emit        = 1'b0;
        emit_long   = 1'b0;
        emit_tag    = 5'd1;

        sh   = {pos_reg[1:0], 3'b000};
        bext = {24'd0, in_byte_reg};
        word = {in_byte_reg, wasm_reg};
        r    = 8'({4'd0, pos_reg} + rem_reg[7:0]);
        t    = r[3:2];
        w    = pos_reg[3:2];
        s    = 2'(w + 2'd3 - t);

        if (in_valid_reg) begin
            if (in_cmd_reg == kbsh_pkg::CMD_START) begin
                lanes_next.a = seed0_reg ^ in_pa_reg;
                lanes_next.b = seed1_reg ^ in_pb_reg;
                lanes_next.c = seed2_reg ^ in_pc_reg;
                lanes_next.d = seed0_reg ^ in_pd_reg;
                rem_next     = in_len_reg;
                wasm_next    = '0;
                pos_next     = '0;
                if (in_len_reg == 32'd0) begin
                    active_next = 1'b0;
                    mode_next   = kbsh_pkg::MODE_SHORT;
                    emit        = 1'b1;
                end else begin
                    active_next = 1'b1;
                    if (in_len_reg <= kbsh_pkg::SHORT_MAX)
                        mode_next = kbsh_pkg::MODE_SHORT;
                    else if (in_len_reg < kbsh_pkg::BLOCK_BYTES)
                        mode_next = kbsh_pkg::MODE_TAIL;
                    else
                        mode_next = kbsh_pkg::MODE_BLOCK;
                end
            end else if (!active_reg || rem_reg == 32'd0) begin
                // stray byte: dropped
                active_next = 1'b0;
            end else begin
                rem_next = rem_reg - 32'd1;
                pos_next = pos_reg + 4'd1;
                if (mode_reg == kbsh_pkg::MODE_SHORT) begin
                    // short key: unsigned byte folds, subtracted and added in turn
                    case (pos_reg[1:0])
                        2'd0:    lanes_next.a = lanes_reg.a - (bext << {pos_reg[3:2], 3'b000});
                        2'd1:    lanes_next.b = lanes_reg.b + (bext << {pos_reg[3:2], 3'b000});
                        2'd2:    lanes_next.c = lanes_reg.c - (bext << {pos_reg[3:2], 3'b000});
                        default: lanes_next.d = lanes_reg.d + (bext << {pos_reg[3:2], 3'b000});
                    endcase
                    if (rem_next == 32'd0) begin
                        active_next = 1'b0;
                        emit        = 1'b1;
                    end
                end else if (mode_reg == kbsh_pkg::MODE_BLOCK) begin
                    // whole 16-byte blocks
                    if (pos_reg[1:0] != 2'd3) begin
                        wasm_next = wasm_reg | 24'(bext << sh);
                    end else begin
                        wasm_next = '0;
                        case (pos_reg[3:2])
                            2'd0: lanes_next.d = lanes_reg.d + word;
                            2'd1: begin
                                lanes_next.c = lanes_reg.c + word;
                                lanes_next   = kbsh_pkg::mix6(lanes_next);
                            end
                            2'd2: lanes_next.b = lanes_reg.b + word;
                            default: begin
                                lanes_next.a = lanes_reg.a + word;
                                lanes_next   = kbsh_pkg::mix6(lanes_next);
                                pos_next     = '0;
                                if (rem_next == 32'd0) begin
                                    active_next = 1'b0;
                                    emit        = 1'b1;
                                    emit_long   = 1'b1;
                                    emit_tag    = 5'd1;
                                end else if (rem_next < kbsh_pkg::BLOCK_BYTES) begin
                                    mode_next = kbsh_pkg::MODE_TAIL;
                                end
                            end
                        endcase
                    end
                end else begin
                    // tail: whole words in fixed order, then loose bytes into a
                    if (w < t) begin
                        if (pos_reg[1:0] != 2'd3) begin
                            wasm_next = wasm_reg | 24'(bext << sh);
                        end else begin
                            wasm_next = '0;
                            case (s)
                                2'd0: lanes_next.d = lanes_reg.d + word;
                                2'd1: begin
                                    lanes_next.c = lanes_reg.c + word;
                                    lanes_next   = kbsh_pkg::mix6(lanes_next);
                                end
                                default: lanes_next.b = lanes_reg.b + word;
                            endcase
                        end
                    end else begin
                        lanes_next.a = lanes_reg.a + (bext << sh);
                    end
                    if (rem_next == 32'd0) begin
                        active_next = 1'b0;
                        emit        = 1'b1;
                        emit_long   = 1'b1;
                        emit_tag    = 5'({1'b0, pos_reg} + 5'd2);
                    end
                end
            end
        end
    end

    // Key state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lanes_reg  <= '0;
            rem_reg    <= '0;
            wasm_reg   <= '0;
            pos_reg    <= '0;
            mode_reg   <= kbsh_pkg::MODE_SHORT;
            active_reg <= 1'b0;
        end else if (adv) begin
            lanes_reg  <= lanes_next;
            rem_reg    <= rem_next;
            wasm_reg   <= wasm_next;
            pos_reg    <= pos_next;
            mode_reg   <= mode_next;
            active_reg <= active_next;
        end
    end

    // Long-key end: length tag, end mark, one mix
    always_comb begin
        f1_work = f1_lanes_reg;
        if (f1_long_reg) begin
            f1_work.a = f1_lanes_reg.a + {3'd0, f1_tag_reg, 24'd0};
            f1_work.d = f1_lanes_reg.d ^ kbsh_pkg::END_MARK;
            f1_work   = kbsh_pkg::mix6(f1_work);
        end
    end

    // Finalize pipe valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            fm_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else if (adv) begin
            f1_valid_reg <= emit;
            fm_valid_reg <= f1_valid_reg;
            f2_valid_reg <= fm_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            m_valid_reg  <= f3_valid_reg;
        end
    end

    // Finalize pipe payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_lanes_reg <= lanes_next;
            f1_long_reg  <= emit_long;
            f1_tag_reg   <= emit_tag;
            fm_lanes_reg <= f1_work;
            f2_lanes_reg <= kbsh_pkg::fin_lo(fm_lanes_reg);
            f3_lanes_reg <= kbsh_pkg::fin_hi(f2_lanes_reg);
            m_data_reg   <= f3_lanes_reg.a ^ f3_lanes_reg.b ^ f3_lanes_reg.c ^ f3_lanes_reg.d;
        end
    end

endmodule
